[rtl/vrp_pkg.sv]
// Shared constants, types and helper functions of the vertex rotate and project block.
package vrp_pkg;

  // Field and arithmetic widths.
  localparam int COORD_W    = 16;
  localparam int COEF_W     = 16;
  localparam int FRAC_W     = 14;
  localparam int OUT_W      = 24;
  localparam int ROT_W      = 25;
  localparam int SIN_W      = COEF_W + 1;
  localparam int PROD_W     = ROT_W + SIN_W;
  localparam int SUM_W      = PROD_W + 1;
  localparam int ISO_W      = ROT_W + 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int NUM_W      = 35;
  localparam int DEN_W      = 22;
  localparam int LANES      = 3;

  // Projection constants.
  localparam logic signed [ISO_W-1:0]   PERSP_CLAMP = ISO_W'(1950);
  localparam logic signed [ISO_W-1:0]   PERSP_BASE  = ISO_W'(2000);
  localparam logic [10:0]               PERSP_MUL   = 11'd2000;
  localparam logic signed [17:0]        ISO_COS_Q16 = 18'sd56756;
  localparam logic signed [SUM_W-1:0]   Q_BIAS      = SUM_W'((1 << FRAC_W) - 1);
  localparam logic signed [SUM_W-1:0]   ISO_BIAS    = SUM_W'(65535);
  localparam logic signed [SUM_W-1:0]   OUT_MAX     = SUM_W'(8388607);
  localparam logic signed [SUM_W-1:0]   OUT_MIN     = -SUM_W'(8388608);

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_COS_BETA  = 3'd0,
    REG_SIN_BETA  = 3'd1,
    REG_COS_ALPHA = 3'd2,
    REG_SIN_ALPHA = 3'd3,
    REG_COS_GAMMA = 3'd4,
    REG_SIN_GAMMA = 3'd5,
    REG_PROJ_MODE = 3'd6
  } cfg_reg_e;

  // Projection modes; the unused code behaves as no projection.
  typedef enum logic [1:0] {
    PROJ_NONE  = 2'd0,
    PROJ_ISO   = 2'd1,
    PROJ_PERSP = 2'd2
  } proj_mode_e;

  // Vertex as it travels through the rotation stages.
  typedef struct packed {
    logic signed [ROT_W-1:0] x;
    logic signed [ROT_W-1:0] y;
    logic signed [ROT_W-1:0] z;
  } vtx_t;

  // Data that rides alongside the divider lanes.
  typedef struct packed {
    vtx_t                    vtx;
    logic signed [SUM_W-1:0] iso_xp;
    logic signed [ISO_W-1:0] iso_ys;
    logic [LANES-1:0]        neg;
    proj_mode_e              mode;
  } side_t;

  // Divide by 2^FRAC_W, truncating toward zero.
  function automatic logic signed [ROT_W-1:0] q_trunc(input logic signed [SUM_W-1:0] s);
    logic signed [SUM_W-1:0] t;
    logic signed [SUM_W-1:0] sh;
    t  = s + (s[SUM_W-1] ? Q_BIAS : '0);
    sh = t >>> FRAC_W;
    return sh[ROT_W-1:0];
  endfunction

  // Clamp to the signed output range.
  function automatic logic [OUT_W-1:0] sat_out(input logic signed [SUM_W-1:0] v);
    logic signed [SUM_W-1:0] c;
    c = v;
    if (v > OUT_MAX) c = OUT_MAX;
    if (v < OUT_MIN) c = OUT_MIN;
    return c[OUT_W-1:0];
  endfunction

endpackage

[rtl/vrp_if.sv]
// Valid/ready channel interfaces for input vertices and projected results.
interface vrp_in_if;
  import vrp_pkg::*;
  logic                      valid;
  logic                      ready;
  logic signed [COORD_W-1:0] x_in;
  logic signed [COORD_W-1:0] y_in;
  logic signed [COORD_W-1:0] z_in;
  modport source (output valid, output x_in, output y_in, output z_in, input ready);
  modport sink   (input valid, input x_in, input y_in, input z_in, output ready);
endinterface

interface vrp_out_if;
  import vrp_pkg::*;
  logic                    valid;
  logic                    ready;
  logic signed [OUT_W-1:0] x_out;
  logic signed [OUT_W-1:0] y_out;
  logic signed [OUT_W-1:0] z_out;
  modport source (output valid, output x_out, output y_out, output z_out, input ready);
  modport sink   (input valid, input x_out, input y_out, input z_out, output ready);
endinterface

[rtl/vrp_rotate.sv]
// Two-stage rotation of the x/y fields of a vertex by a cosine/sine pair; z passes through.
module vrp_rotate (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            valid_i,
  output logic                            ready_o,
  input  vrp_pkg::vtx_t                   vtx_i,
  input  logic signed [vrp_pkg::COEF_W-1:0] cos_i,
  input  logic signed [vrp_pkg::SIN_W-1:0]  sin_i,
  output logic                            valid_o,
  input  logic                            ready_i,
  output vrp_pkg::vtx_t                   vtx_o
);
  import vrp_pkg::*;

  logic                     v1_q, v2_q;
  logic                     rdy1, rdy2;
  logic signed [PROD_W-1:0] p_ac_d, p_bs_d, p_bc_d, p_as_d;
  logic signed [PROD_W-1:0] p_ac_q, p_bs_q, p_bc_q, p_as_q;
  logic signed [ROT_W-1:0]  c_q;
  logic signed [SUM_W-1:0]  s_a, s_b;
  vtx_t                     vtx_d, vtx_q;

  // A stage moves when it is empty or its successor moves.
  assign rdy2    = !v2_q || ready_i;
  assign rdy1    = !v1_q || rdy2;
  assign ready_o = rdy1;

  // First stage: the four products.
  assign p_ac_d = vtx_i.x * cos_i;
  assign p_bs_d = vtx_i.y * sin_i;
  assign p_bc_d = vtx_i.y * cos_i;
  assign p_as_d = vtx_i.x * sin_i;

  // Second stage: sums and truncation.
  always_comb begin
    s_a     = SUM_W'(p_ac_q) + SUM_W'(p_bs_q);
    s_b     = SUM_W'(p_bc_q) - SUM_W'(p_as_q);
    vtx_d.x = q_trunc(s_a);
    vtx_d.y = q_trunc(s_b);
    vtx_d.z = c_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= valid_i;
      if (rdy2) v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy1 && valid_i) begin
      p_ac_q <= p_ac_d;
      p_bs_q <= p_bs_d;
      p_bc_q <= p_bc_d;
      p_as_q <= p_as_d;
      c_q    <= vtx_i.z;
    end
    if (rdy2 && v1_q) vtx_q <= vtx_d;
  end

  assign valid_o = v2_q;
  assign vtx_o   = vtx_q;

endmodule

[rtl/vrp_divider.sv]
// Pipelined restoring divider: three unsigned lanes, one quotient bit per stage.
module vrp_divider (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       valid_i,
  output logic                       ready_o,
  input  logic [vrp_pkg::NUM_W-1:0]  num_i [vrp_pkg::LANES],
  input  logic [vrp_pkg::DEN_W-1:0]  den_i,
  input  vrp_pkg::side_t             side_i,
  output logic                       valid_o,
  input  logic                       ready_i,
  output logic [vrp_pkg::NUM_W-1:0]  quot_o [vrp_pkg::LANES],
  output vrp_pkg::side_t             side_o
);
  import vrp_pkg::*;

  logic               v_q   [NUM_W];
  logic               rdy   [NUM_W];
  logic [DEN_W-1:0]   rem_q [NUM_W][LANES];
  logic [NUM_W-1:0]   nq_q  [NUM_W][LANES];
  logic [DEN_W-1:0]   den_q [NUM_W];
  side_t              side_q[NUM_W];

  assign ready_o = rdy[0];

  for (genvar k = 0; k < NUM_W; k++) begin : g_stage
    logic             in_v;
    logic [DEN_W-1:0] in_rem [LANES];
    logic [NUM_W-1:0] in_nq  [LANES];
    logic [DEN_W-1:0] in_den;
    side_t            in_side;
    logic [DEN_W-1:0] rem_d  [LANES];
    logic [NUM_W-1:0] nq_d   [LANES];

    // Stage inputs come from the ports or the previous stage.
    if (k == 0) begin : g_first
      assign in_v    = valid_i;
      assign in_den  = den_i;
      assign in_side = side_i;
      for (genvar l = 0; l < LANES; l++) begin : g_lane
        assign in_rem[l] = '0;
        assign in_nq[l]  = num_i[l];
      end
    end else begin : g_next
      assign in_v    = v_q[k-1];
      assign in_den  = den_q[k-1];
      assign in_side = side_q[k-1];
      for (genvar l = 0; l < LANES; l++) begin : g_lane
        assign in_rem[l] = rem_q[k-1][l];
        assign in_nq[l]  = nq_q[k-1][l];
      end
    end

    if (k == NUM_W - 1) begin : g_last_rdy
      assign rdy[k] = !v_q[k] || ready_i;
    end else begin : g_mid_rdy
      assign rdy[k] = !v_q[k] || rdy[k+1];
    end

    // One restoring step: shift in the next dividend bit, subtract if it fits.
    always_comb begin
      logic [DEN_W:0] sh;
      logic           fit;
      for (int l = 0; l < LANES; l++) begin
        sh  = {in_rem[l], in_nq[l][NUM_W-1]};
        fit = (sh >= {1'b0, in_den});
        if (fit) begin
          sh = sh - {1'b0, in_den};
        end
        rem_d[l] = sh[DEN_W-1:0];
        nq_d[l]  = {in_nq[l][NUM_W-2:0], fit};
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (rdy[k]) begin
        v_q[k] <= in_v;
      end
    end

    always_ff @(posedge clk_i) begin
      if (rdy[k] && in_v) begin
        den_q[k]  <= in_den;
        side_q[k] <= in_side;
        for (int l = 0; l < LANES; l++) begin
          rem_q[k][l] <= rem_d[l];
          nq_q[k][l]  <= nq_d[l];
        end
      end
    end
  end

  assign valid_o = v_q[NUM_W-1];
  assign side_o  = side_q[NUM_W-1];
  for (genvar l = 0; l < LANES; l++) begin : g_out
    assign quot_o[l] = nq_q[NUM_W-1][l];
  end

endmodule

[rtl/vrp_project.sv]
// Projection: operand setup stage, divider pipeline, and the selecting/saturating output stage.
module vrp_project (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            valid_i,
  output logic                            ready_o,
  input  vrp_pkg::vtx_t                   vtx_i,
  input  vrp_pkg::proj_mode_e             mode_i,
  output logic                            valid_o,
  input  logic                            ready_i,
  output logic signed [vrp_pkg::OUT_W-1:0] x_o,
  output logic signed [vrp_pkg::OUT_W-1:0] y_o,
  output logic signed [vrp_pkg::OUT_W-1:0] z_o
);
  import vrp_pkg::*;

  logic                    p1_v_q, p1_rdy;
  logic [NUM_W-1:0]        num_d [LANES];
  logic [NUM_W-1:0]        num_q [LANES];
  logic [DEN_W-1:0]        den_d, den_q;
  side_t                   side_d, side_q;
  logic signed [ISO_W-1:0] pz, den_s;
  logic [ROT_W-1:0]        mag [LANES];
  logic signed [ROT_W:0]   dxy;

  logic                    div_rdy, div_v;
  logic [NUM_W-1:0]        quot [LANES];
  side_t                   div_side;

  logic                    out_v_q, out_rdy;
  logic [OUT_W-1:0]        res_d [LANES];
  logic [OUT_W-1:0]        res_q [LANES];

  // Setup stage: perspective operands and isometric products.
  always_comb begin
    pz     = (ISO_W'(vtx_i.z) > PERSP_CLAMP) ? PERSP_CLAMP : ISO_W'(vtx_i.z);
    den_s  = PERSP_BASE - pz;
    den_d  = den_s[DEN_W-1:0];
    mag[0] = vtx_i.x[ROT_W-1] ? ROT_W'(-vtx_i.x) : ROT_W'(vtx_i.x);
    mag[1] = vtx_i.y[ROT_W-1] ? ROT_W'(-vtx_i.y) : ROT_W'(vtx_i.y);
    mag[2] = pz[ISO_W-1] ? ROT_W'(-pz) : ROT_W'(pz);
    for (int l = 0; l < LANES; l++) begin
      num_d[l] = NUM_W'(mag[l]) * NUM_W'(PERSP_MUL);
    end
    dxy            = (ROT_W+1)'(vtx_i.x) - (ROT_W+1)'(vtx_i.y);
    side_d.vtx     = vtx_i;
    side_d.iso_xp  = SUM_W'(dxy) * SUM_W'(ISO_COS_Q16);
    side_d.iso_ys  = ISO_W'(vtx_i.x) + ISO_W'(vtx_i.y) - (ISO_W'(vtx_i.z) <<< 1);
    side_d.neg     = {pz[ISO_W-1], vtx_i.y[ROT_W-1], vtx_i.x[ROT_W-1]};
    side_d.mode    = mode_i;
  end

  assign p1_rdy  = !p1_v_q || div_rdy;
  assign ready_o = p1_rdy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_v_q <= 1'b0;
    end else if (p1_rdy) begin
      p1_v_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (p1_rdy && valid_i) begin
      num_q  <= num_d;
      den_q  <= den_d;
      side_q <= side_d;
    end
  end

  vrp_divider u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (p1_v_q),
    .ready_o (div_rdy),
    .num_i   (num_q),
    .den_i   (den_q),
    .side_i  (side_q),
    .valid_o (div_v),
    .ready_i (out_rdy),
    .quot_o  (quot),
    .side_o  (div_side)
  );

  // Output stage: pick the result by mode, truncate toward zero and saturate.
  always_comb begin
    logic signed [SUM_W-1:0] q_s [LANES];
    logic signed [SUM_W-1:0] ix, iy;
    for (int l = 0; l < LANES; l++) begin
      q_s[l] = div_side.neg[l] ? -SUM_W'(quot[l]) : SUM_W'(quot[l]);
    end
    // The bias and the shift stay signed so negative values round toward zero.
    ix = div_side.iso_xp + (div_side.iso_xp[SUM_W-1] ? ISO_BIAS : SUM_W'(0));
    ix = ix >>> 16;
    iy = SUM_W'(div_side.iso_ys);
    iy = iy + (iy[SUM_W-1] ? SUM_W'(1) : SUM_W'(0));
    iy = iy >>> 1;
    unique case (div_side.mode)
      PROJ_ISO: begin
        res_d[0] = sat_out(ix);
        res_d[1] = sat_out(iy);
        res_d[2] = sat_out(SUM_W'(div_side.vtx.z));
      end
      PROJ_PERSP: begin
        for (int l = 0; l < LANES; l++) res_d[l] = sat_out(q_s[l]);
      end
      default: begin
        res_d[0] = sat_out(SUM_W'(div_side.vtx.x));
        res_d[1] = sat_out(SUM_W'(div_side.vtx.y));
        res_d[2] = sat_out(SUM_W'(div_side.vtx.z));
      end
    endcase
  end

  assign out_rdy = !out_v_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (out_rdy) begin
      out_v_q <= div_v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_rdy && div_v) res_q <= res_d;
  end

  assign valid_o = out_v_q;
  assign x_o     = res_q[0];
  assign y_o     = res_q[1];
  assign z_o     = res_q[2];

endmodule

[rtl/vertex_rotate_project_core.sv]
// Top level: configuration registers, three rotation units and the projection pipeline.
// A request passes the product and sum stages of each rotation axis,
// 1 setup stage, 35 divider stages (one quotient bit each) and 1 output register.
// Throughput is one vertex per cycle while the output is ready; each stage holds when stalled and bubbles collapse.
// Reset clears all valid bits, sets the cosines to 1.0, the sines to 0 and the mode to none.
module vertex_rotate_project_core (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [vrp_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [vrp_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  vrp_in_if.sink                              vin_i,
  vrp_out_if.source                           vout_o
);
  import vrp_pkg::*;

  logic signed [COEF_W-1:0] cb_q, sb_q, ca_q, sa_q, cg_q, sg_q;
  proj_mode_e               mode_q;
  logic signed [SIN_W-1:0]  sin_b, sin_a, sin_g_neg;

  logic  rx_v, rx_rdy, ry_v, ry_rdy, rz_v, rz_rdy, pj_rdy;
  vtx_t  rx_in, rx_out, ry_in, ry_out, rz_in, rz_out, pj_in;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cb_q   <= COEF_W'(16384);
      sb_q   <= '0;
      ca_q   <= COEF_W'(16384);
      sa_q   <= '0;
      cg_q   <= COEF_W'(16384);
      sg_q   <= '0;
      mode_q <= PROJ_NONE;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_COS_BETA:  cb_q   <= cfg_data_i;
        REG_SIN_BETA:  sb_q   <= cfg_data_i;
        REG_COS_ALPHA: ca_q   <= cfg_data_i;
        REG_SIN_ALPHA: sa_q   <= cfg_data_i;
        REG_COS_GAMMA: cg_q   <= cfg_data_i;
        REG_SIN_GAMMA: sg_q   <= cfg_data_i;
        REG_PROJ_MODE: mode_q <= proj_mode_e'(cfg_data_i[1:0]);
        default: ;
      endcase
    end
  end

  // The z-axis unit gets the negated sine so all three share one form.
  assign sin_b     = SIN_W'(sb_q);
  assign sin_a     = SIN_W'(sa_q);
  assign sin_g_neg = -SIN_W'(sg_q);

  // Rotation about x: (y, z) rotate, x passes.
  assign rx_in.x = ROT_W'(vin_i.y_in);
  assign rx_in.y = ROT_W'(vin_i.z_in);
  assign rx_in.z = ROT_W'(vin_i.x_in);
  assign vin_i.ready = rx_rdy;

  vrp_rotate u_rot_x (
    .clk_i (clk_i), .rst_ni (rst_ni),
    .valid_i (vin_i.valid), .ready_o (rx_rdy), .vtx_i (rx_in),
    .cos_i (cb_q), .sin_i (sin_b),
    .valid_o (rx_v), .ready_i (ry_rdy), .vtx_o (rx_out)
  );

  // Rotation about y: (x, z) rotate, y passes.
  assign ry_in.x = rx_out.z;
  assign ry_in.y = rx_out.y;
  assign ry_in.z = rx_out.x;

  vrp_rotate u_rot_y (
    .clk_i (clk_i), .rst_ni (rst_ni),
    .valid_i (rx_v), .ready_o (ry_rdy), .vtx_i (ry_in),
    .cos_i (ca_q), .sin_i (sin_a),
    .valid_o (ry_v), .ready_i (rz_rdy), .vtx_o (ry_out)
  );

  // Rotation about z: (x, y) rotate, z passes.
  assign rz_in.x = ry_out.x;
  assign rz_in.y = ry_out.z;
  assign rz_in.z = ry_out.y;

  vrp_rotate u_rot_z (
    .clk_i (clk_i), .rst_ni (rst_ni),
    .valid_i (ry_v), .ready_o (rz_rdy), .vtx_i (rz_in),
    .cos_i (cg_q), .sin_i (sin_g_neg),
    .valid_o (rz_v), .ready_i (pj_rdy), .vtx_o (rz_out)
  );

  assign pj_in = rz_out;

  vrp_project u_proj (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (rz_v),
    .ready_o (pj_rdy),
    .vtx_i   (pj_in),
    .mode_i  (mode_q),
    .valid_o (vout_o.valid),
    .ready_i (vout_o.ready),
    .x_o     (vout_o.x_out),
    .y_o     (vout_o.y_out),
    .z_o     (vout_o.z_out)
  );

endmodule
